// ----- hw/rtl/rrts_pkg.sv -----
// rrts_pkg: shared constants, slot state codes, operation and status codes
// and a small helper function for the round-robin task scheduler
// no dependencies
package rrts_pkg;

  // default sizes of the task table
  localparam int MaxTasksDef = 16;
  localparam int PidBitsDef  = 16;
  localparam int TickBitsDef = 64;

  // fixed field widths of the channels
  localparam int OpW     = 3;
  localparam int TickW   = 64;
  localparam int PidW    = 16;
  localparam int SlotW   = 4;
  localparam int StatusW = 2;
  localparam int StateW  = 3;

  // operation codes
  localparam logic [OpW-1:0] OP_TICK   = 3'd0;
  localparam logic [OpW-1:0] OP_CREATE = 3'd1;
  localparam logic [OpW-1:0] OP_EXIT   = 3'd2;
  localparam logic [OpW-1:0] OP_SLEEP  = 3'd3;
  localparam logic [OpW-1:0] OP_WAIT   = 3'd4;
  localparam logic [OpW-1:0] OP_QUERY  = 3'd5;
  localparam logic [OpW-1:0] OP_MARK   = 3'd6;
  // spare code, does nothing
  localparam logic [OpW-1:0] OP_UNUSED = 3'd7;

  // slot states
  localparam logic [StateW-1:0] ST_FREE     = 3'd0;
  localparam logic [StateW-1:0] ST_READY    = 3'd1;
  localparam logic [StateW-1:0] ST_RUNNING  = 3'd2;
  localparam logic [StateW-1:0] ST_SLEEPING = 3'd3;
  localparam logic [StateW-1:0] ST_WAITING  = 3'd4;
  localparam logic [StateW-1:0] ST_DEAD     = 3'd5;

  // create status codes
  localparam logic [StatusW-1:0] STAT_OK   = 2'd0;
  localparam logic [StatusW-1:0] STAT_FULL = 2'd1;
  localparam logic [StatusW-1:0] STAT_EXH  = 2'd2;

  // a slot that cannot be picked to run
  function automatic logic is_blocked(input logic [StateW-1:0] s);
    return (s == ST_DEAD) || (s == ST_SLEEPING) || (s == ST_WAITING);
  endfunction

endpackage

// ----- hw/rtl/rrts_if.sv -----
// rrts_in_if / rrts_out_if: valid/ready channels of the task scheduler
// depends on rrts_pkg
interface rrts_in_if import rrts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OpW-1:0]     operation;
  logic [TickW-1:0]   now_tick;
  logic [TickW-1:0]   wake_at;
  logic [PidW-1:0]    peer_pid;
  logic               syscall_active;

  modport source (output valid, operation, now_tick, wake_at, peer_pid,
                  syscall_active, input ready);
  modport sink   (input valid, operation, now_tick, wake_at, peer_pid,
                  syscall_active, output ready);
endinterface

interface rrts_out_if import rrts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SlotW-1:0]   running_slot;
  logic [PidW-1:0]    running_pid;
  logic               switched;
  logic [PidW-1:0]    new_pid;
  logic               dead_answer;
  logic [StatusW-1:0] status;

  modport source (output valid, running_slot, running_pid, switched, new_pid,
                  dead_answer, status, input ready);
  modport sink   (input valid, running_slot, running_pid, switched, new_pid,
                  dead_answer, status, output ready);
endinterface

// ----- hw/rtl/round_robin_task_scheduler.sv -----
// Round-robin task scheduler: task table, sequencer and result register.
// Create, exit, sleep, mark running, an unknown operation and a tick during a
// syscall finish without walking the table. Wait and query dead walk the table
// one slot a cycle with a single pid comparator. A tick walks the table twice
// (wake of due sleepers through one shared tick comparator, then reaping and
// compaction), then clears the tail; when more than one task remains it then
// steps the round-robin search one slot a cycle. The result is registered and
// shown in the cycle after the work ends, and the block takes no new
// transaction until it has been taken. Depends on rrts_pkg and rrts_if.
module round_robin_task_scheduler import rrts_pkg::*; #(
  parameter int MAX_TASKS = MaxTasksDef,
  parameter int PID_BITS  = PidBitsDef,
  parameter int TICK_BITS = TickBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rrts_in_if.sink   in_i,
  rrts_out_if.source out_o
);

  localparam int SW  = $clog2(MAX_TASKS);
  localparam int CW  = $clog2(MAX_TASKS + 1);
  localparam int CW1 = CW + 1;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WAKE  = 3'd1;
  localparam logic [2:0] S_REAP  = 3'd2;
  localparam logic [2:0] S_CLEAN = 3'd3;
  localparam logic [2:0] S_PICK  = 3'd4;
  localparam logic [2:0] S_FIND  = 3'd5;

  // task table
  logic [StateW-1:0]    st_q [MAX_TASKS];
  logic [PID_BITS-1:0]  pid_q [MAX_TASKS];
  logic [TICK_BITS-1:0] wk_q [MAX_TASKS];
  logic [PID_BITS-1:0]  wp_q [MAX_TASKS];
  logic [CW-1:0]        used_q;
  logic [SW-1:0]        cur_q;
  logic [PID_BITS-1:0]  pidc_q;

  // sequencer state
  logic [2:0]           seq_q;
  logic [SW-1:0]        idx_q;
  logic [CW-1:0]        j_q;
  logic [SW-1:0]        ncur_q;
  logic [SW-1:0]        cand_q;
  logic [CW1-1:0]       att_q;
  logic [TICK_BITS-1:0] now_q;
  logic [OpW-1:0]       op_q;
  logic [PidW-1:0]      tgt_q;

  // result register
  logic                 ov_q;
  logic                 sw_q;
  logic [PidW-1:0]      np_q;
  logic                 dead_q;
  logic [StatusW-1:0]   stat_q;

  logic                 acc;
  logic                 idx_last;
  logic                 wake_due;
  logic                 reap_skip;
  logic                 do_copy;
  logic                 pid_hit;
  logic                 wait_set;
  logic [SW-1:0]        nxt;
  logic [CW1-1:0]       att_n;
  logic                 wake_en;
  logic [PID_BITS-1:0]  wake_pid;
  logic                 is_exit;

  // handshake
  assign in_i.ready = (seq_q == S_IDLE) && !ov_q;
  assign acc        = in_i.valid && in_i.ready;
  assign is_exit    = acc && (in_i.operation == OP_EXIT);

  // walk control and shared compare units
  assign idx_last  = (CW1'(idx_q) + CW1'(1)) == CW1'(used_q);
  assign wake_due  = (st_q[idx_q] == ST_SLEEPING) && (now_q >= wk_q[idx_q]);
  assign reap_skip = (st_q[idx_q] == ST_DEAD) && (idx_q != cur_q);
  assign do_copy   = (seq_q == S_REAP) && !reap_skip;
  assign pid_hit   = 32'(pid_q[idx_q]) == 32'(tgt_q);
  assign wait_set  = (seq_q == S_FIND) && pid_hit && (op_q == OP_WAIT) &&
                     (st_q[idx_q] != ST_DEAD);
  assign nxt       = ((CW1'(cand_q) + CW1'(1)) >= CW1'(used_q)) ? '0 :
                     SW'(CW1'(cand_q) + CW1'(1));
  assign att_n     = att_q + CW1'(1);

  // waiter release on a reaped slot or on exit
  assign wake_en  = ((seq_q == S_REAP) && reap_skip) || is_exit;
  assign wake_pid = (seq_q == S_REAP) ? pid_q[idx_q] : pid_q[cur_q];

  // control state and the resettable part of the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_TASKS; k++) begin
        st_q[k]  <= (k == 0) ? ST_RUNNING : ST_FREE;
        pid_q[k] <= '0;
      end
      used_q <= CW'(1);
      cur_q  <= '0;
      pidc_q <= PID_BITS'(1);
      seq_q  <= S_IDLE;
      idx_q  <= '0;
      j_q    <= '0;
      ncur_q <= '0;
      cand_q <= '0;
      att_q  <= '0;
      ov_q   <= 1'b0;
      sw_q   <= 1'b0;
      np_q   <= '0;
      dead_q <= 1'b0;
      stat_q <= STAT_OK;
    end else begin
      if (out_o.valid && out_o.ready) begin
        ov_q <= 1'b0;
      end

      // the exiting slot itself becomes dead rather than ready
      if (wake_en) begin
        for (int k = 0; k < MAX_TASKS; k++) begin
          if ((st_q[k] == ST_WAITING) && (wp_q[k] == wake_pid) &&
              !(is_exit && (k == int'(cur_q)))) begin
            st_q[k] <= ST_READY;
          end
        end
      end

      case (seq_q)
        S_IDLE: begin
          if (acc) begin
            sw_q   <= 1'b0;
            np_q   <= '0;
            dead_q <= 1'b0;
            stat_q <= STAT_OK;
            case (in_i.operation)
              OP_TICK: begin
                if (in_i.syscall_active) begin
                  ov_q <= 1'b1;
                end else begin
                  idx_q <= '0;
                  seq_q <= S_WAKE;
                end
              end
              OP_CREATE: begin
                ov_q <= 1'b1;
                if (used_q == CW'(MAX_TASKS)) begin
                  stat_q <= STAT_FULL;
                end else if (pidc_q == '0) begin
                  stat_q <= STAT_EXH;
                end else begin
                  st_q[used_q[SW-1:0]]  <= ST_READY;
                  pid_q[used_q[SW-1:0]] <= pidc_q;
                  np_q                  <= PidW'(32'(pidc_q));
                  pidc_q                <= pidc_q + PID_BITS'(1);
                  used_q                <= used_q + CW'(1);
                end
              end
              OP_EXIT: begin
                st_q[cur_q] <= ST_DEAD;
                ov_q        <= 1'b1;
              end
              OP_SLEEP: begin
                st_q[cur_q] <= ST_SLEEPING;
                ov_q        <= 1'b1;
              end
              OP_WAIT, OP_QUERY: begin
                idx_q <= '0;
                seq_q <= S_FIND;
              end
              OP_MARK: begin
                st_q[cur_q] <= ST_RUNNING;
                ov_q        <= 1'b1;
              end
              default: begin
                ov_q <= 1'b1;
              end
            endcase
          end
        end

        // wake the sleepers that are due
        S_WAKE: begin
          if (wake_due) begin
            st_q[idx_q] <= ST_READY;
          end
          if (idx_last) begin
            idx_q  <= '0;
            j_q    <= '0;
            ncur_q <= cur_q;
            seq_q  <= S_REAP;
          end else begin
            idx_q <= idx_q + SW'(1);
          end
        end

        // reap dead slots and pack the survivors down
        S_REAP: begin
          if (!reap_skip) begin
            st_q[j_q[SW-1:0]]  <= st_q[idx_q];
            pid_q[j_q[SW-1:0]] <= pid_q[idx_q];
            if (idx_q == cur_q) begin
              ncur_q <= j_q[SW-1:0];
            end
            j_q <= j_q + CW'(1);
          end
          if (idx_last) begin
            seq_q <= S_CLEAN;
          end else begin
            idx_q <= idx_q + SW'(1);
          end
        end

        // free the tail and, when more than one task remains, start the round-robin search
        S_CLEAN: begin
          for (int k = 0; k < MAX_TASKS; k++) begin
            if ((CW'(k) >= j_q) && (CW'(k) < used_q)) begin
              st_q[k]  <= ST_FREE;
              pid_q[k] <= '0;
            end
          end
          used_q <= j_q;
          cur_q  <= ncur_q;
          if (j_q <= CW'(1)) begin
            ov_q  <= 1'b1;
            seq_q <= S_IDLE;
          end else begin
            if (st_q[ncur_q] == ST_RUNNING) begin
              st_q[ncur_q] <= ST_READY;
            end
            cand_q <= ncur_q;
            att_q  <= '0;
            seq_q  <= S_PICK;
          end
        end

        // one candidate a cycle, slot 0 when nothing is runnable
        S_PICK: begin
          if (att_n > CW1'(used_q)) begin
            cur_q   <= '0;
            st_q[0] <= ST_RUNNING;
            sw_q    <= 1'b1;
            ov_q    <= 1'b1;
            seq_q   <= S_IDLE;
          end else if (!is_blocked(st_q[nxt])) begin
            cur_q     <= nxt;
            st_q[nxt] <= ST_RUNNING;
            sw_q      <= 1'b1;
            ov_q      <= 1'b1;
            seq_q     <= S_IDLE;
          end else begin
            cand_q <= nxt;
            att_q  <= att_n;
          end
        end

        // pid lookup for wait and query dead
        S_FIND: begin
          if (pid_hit) begin
            if (wait_set) begin
              st_q[cur_q] <= ST_WAITING;
            end
            if (op_q == OP_QUERY) begin
              dead_q <= (st_q[idx_q] == ST_DEAD);
            end
            ov_q  <= 1'b1;
            seq_q <= S_IDLE;
          end else if (idx_last) begin
            if (op_q == OP_QUERY) begin
              dead_q <= 1'b1;
            end
            ov_q  <= 1'b1;
            seq_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + SW'(1);
          end
        end

        default: begin
          seq_q <= S_IDLE;
        end
      endcase
    end
  end

  // wake times, wait pids and latched transaction fields
  always_ff @(posedge clk_i) begin
    if (acc) begin
      now_q <= in_i.now_tick[TICK_BITS-1:0];
      op_q  <= in_i.operation;
      tgt_q <= in_i.peer_pid;
      if (in_i.operation == OP_SLEEP) begin
        wk_q[cur_q] <= in_i.wake_at[TICK_BITS-1:0];
      end
    end
    if (do_copy) begin
      wk_q[j_q[SW-1:0]] <= wk_q[idx_q];
      wp_q[j_q[SW-1:0]] <= wp_q[idx_q];
    end
    if (wait_set) begin
      wp_q[cur_q] <= PID_BITS'(32'(tgt_q));
    end
  end

  // result channel
  assign out_o.valid        = ov_q;
  assign out_o.running_slot = SlotW'(32'(cur_q));
  assign out_o.running_pid  = PidW'(32'(pid_q[cur_q]));
  assign out_o.switched     = sw_q;
  assign out_o.new_pid      = np_q;
  assign out_o.dead_answer  = dead_q;
  assign out_o.status       = stat_q;

endmodule
